FILE: design/nearest_resize_index_map_core_defines.svh
// Assertion macros shared by the nearest-resize index map design files.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef NEAREST_RESIZE_INDEX_MAP_CORE_DEFINES_SVH
`define NEAREST_RESIZE_INDEX_MAP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define NRIM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define NRIM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define NRIM_ASSERT(lbl, ante, cons, msg)
`define NRIM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: design/nrim_pkg.sv
`timescale 1ns / 1ps
// Package for the nearest-resize index map: field widths, defaults and register codes.
// Used by every module of the design; it depends on nothing else.
package nrim_pkg;

  // Number of dimensions handled by the datapath.
  localparam int NDIM = 4;

  // Fixed widths of the register and word fields.
  localparam int LEN_W     = 13;
  localparam int RATIO_W   = 28;
  localparam int COORD_W   = 16;
  localparam int INDEX_W   = 48;
  localparam int CFG_IDX_W = 3;
  localparam int PROD_W    = COORD_W + RATIO_W;

  // Parameter defaults.
  localparam int RANK_DEF      = 4;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DIM_BITS_DEF  = 12;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IN_LEN_0 = 3'd0,
    REG_IN_LEN_1 = 3'd1,
    REG_IN_LEN_2 = 3'd2,
    REG_IN_LEN_3 = 3'd3,
    REG_RATIO_0  = 3'd4,
    REG_RATIO_1  = 3'd5,
    REG_RATIO_2  = 3'd6,
    REG_RATIO_3  = 3'd7
  } cfg_reg_t;

endpackage

FILE: design/nrim_cfg.sv
`timescale 1ns / 1ps
// Configuration registers and the effective size of each dimension.
// Depends on nrim_pkg.
module nrim_cfg #(
  parameter int RANK      = nrim_pkg::RANK_DEF,
  parameter int FRAC_BITS = nrim_pkg::FRAC_BITS_DEF,
  parameter int DIM_BITS  = nrim_pkg::DIM_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              cfg_valid,
  output logic                                              cfg_ready,
  input  logic [nrim_pkg::CFG_IDX_W-1:0]                    cfg_index,
  input  logic [nrim_pkg::RATIO_W-1:0]                      cfg_data,
  output logic [nrim_pkg::NDIM-1:0][nrim_pkg::RATIO_W-1:0]  ratio,
  output logic [nrim_pkg::NDIM-1:0][DIM_BITS:0]             len,
  output logic [nrim_pkg::NDIM-1:0][DIM_BITS-1:0]           len_m1
);

  // Width that holds both a register size and the size cap.
  localparam int CW = (nrim_pkg::LEN_W > DIM_BITS + 1) ? nrim_pkg::LEN_W : DIM_BITS + 1;

  logic [nrim_pkg::NDIM-1:0][nrim_pkg::LEN_W-1:0] in_len;
  logic [nrim_pkg::NDIM-1:0][CW-1:0]              eff;
  logic [CW-1:0]                                  cap;

  // The port always takes a write.
  assign cfg_ready = 1'b1;

  // Register file; the ratio resets to 1.0 in fixed point.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int d = 0; d < nrim_pkg::NDIM; d++) begin
        in_len[d] <= nrim_pkg::LEN_W'(1);
        ratio[d]  <= nrim_pkg::RATIO_W'(1) << FRAC_BITS;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (nrim_pkg::cfg_reg_t'(cfg_index))
        nrim_pkg::REG_IN_LEN_0: in_len[0] <= cfg_data[nrim_pkg::LEN_W-1:0];
        nrim_pkg::REG_IN_LEN_1: in_len[1] <= cfg_data[nrim_pkg::LEN_W-1:0];
        nrim_pkg::REG_IN_LEN_2: in_len[2] <= cfg_data[nrim_pkg::LEN_W-1:0];
        nrim_pkg::REG_IN_LEN_3: in_len[3] <= cfg_data[nrim_pkg::LEN_W-1:0];
        nrim_pkg::REG_RATIO_0:  ratio[0]  <= cfg_data;
        nrim_pkg::REG_RATIO_1:  ratio[1]  <= cfg_data;
        nrim_pkg::REG_RATIO_2:  ratio[2]  <= cfg_data;
        nrim_pkg::REG_RATIO_3:  ratio[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective size: zero acts as one, oversize is capped, outer unused dimensions are one.
  assign cap = CW'(1) << DIM_BITS;
  always_comb begin
    for (int d = 0; d < nrim_pkg::NDIM; d++) begin
      if (d < nrim_pkg::NDIM - RANK) begin
        eff[d] = CW'(1);
      end else if (in_len[d] == '0) begin
        eff[d] = CW'(1);
      end else if (CW'(in_len[d]) > cap) begin
        eff[d] = cap;
      end else begin
        eff[d] = CW'(in_len[d]);
      end
      len[d]    = (DIM_BITS + 1)'(eff[d]);
      len_m1[d] = DIM_BITS'(eff[d] - CW'(1));
    end
  end

endmodule

FILE: design/nrim_scale.sv
`timescale 1ns / 1ps
// Two pipeline stages: scale each coordinate by its ratio, then round half up and clamp.
// Depends on nrim_pkg and the assertion macro header.
`include "nearest_resize_index_map_core_defines.svh"
module nrim_scale #(
  parameter int RANK      = nrim_pkg::RANK_DEF,
  parameter int FRAC_BITS = nrim_pkg::FRAC_BITS_DEF,
  parameter int DIM_BITS  = nrim_pkg::DIM_BITS_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  output logic                                              in_ready,
  input  logic [nrim_pkg::NDIM-1:0][nrim_pkg::COORD_W-1:0]  coord,
  input  logic [nrim_pkg::NDIM-1:0][nrim_pkg::RATIO_W-1:0]  ratio,
  input  logic [nrim_pkg::NDIM-1:0][DIM_BITS-1:0]           len_m1,
  output logic                                              out_valid,
  input  logic                                              out_ready,
  output logic [nrim_pkg::NDIM-1:0][DIM_BITS-1:0]           src,
  output logic                                              clip
);

  localparam int PW    = nrim_pkg::PROD_W;
  localparam int RND_W = PW + 1 - FRAC_BITS;
  localparam logic [PW:0] HALF = (PW + 1)'(1) << (FRAC_BITS - 1);

  logic                                   v1;
  logic                                   v2;
  logic                                   rdy1;
  logic                                   rdy2;
  logic [nrim_pkg::NDIM-1:0][PW-1:0]      prod;
  logic [nrim_pkg::NDIM-1:0][PW-1:0]      prod_next;
  logic [nrim_pkg::NDIM-1:0][PW:0]        sum;
  logic [nrim_pkg::NDIM-1:0][RND_W-1:0]   rnd;
  logic [nrim_pkg::NDIM-1:0]              over;
  logic [nrim_pkg::NDIM-1:0][DIM_BITS-1:0] src_next;
  logic                                   clip_next;

  // A stage takes a word when it is empty or its successor takes its word.
  assign rdy2     = !v2 || out_ready;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;
  assign out_valid = v2;

  // Stage one: exact products.
  always_comb begin
    for (int d = 0; d < nrim_pkg::NDIM; d++) begin
      prod_next[d] = PW'(coord[d]) * PW'(ratio[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      prod <= prod_next;
    end
  end

  // Stage two: round half up, clamp to size minus one; unused dimensions give zero.
  always_comb begin
    clip_next = 1'b0;
    for (int d = 0; d < nrim_pkg::NDIM; d++) begin
      sum[d]  = (PW + 1)'(prod[d]) + HALF;
      rnd[d]  = sum[d][PW:FRAC_BITS];
      over[d] = rnd[d] > RND_W'(len_m1[d]);
      if (d < nrim_pkg::NDIM - RANK) begin
        src_next[d] = '0;
      end else begin
        src_next[d] = over[d] ? len_m1[d] : DIM_BITS'(rnd[d]);
        clip_next   = clip_next | over[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      src  <= src_next;
      clip <= clip_next;
    end
  end

  // A taken word always lands in stage one.
  `NRIM_ASSERT_NEXT(a_take_fills, in_valid && in_ready, v1, "accepted word did not enter stage one")

  // Every source coordinate leaving this unit lies inside its dimension.
  for (genvar d = 0; d < nrim_pkg::NDIM; d++) begin : g_chk
    `NRIM_ASSERT(a_src_range, v2, src[d] <= len_m1[d], "source coordinate beyond size")
  end

endmodule

FILE: design/nrim_flatten.sv
`timescale 1ns / 1ps
// Three pipeline stages that fold the source coordinates into a row-major flat index.
// Depends on nrim_pkg and the assertion macro header.
`include "nearest_resize_index_map_core_defines.svh"
module nrim_flatten #(
  parameter int DIM_BITS = nrim_pkg::DIM_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [nrim_pkg::NDIM-1:0][DIM_BITS-1:0] src,
  input  logic                                    clip_in,
  input  logic [nrim_pkg::NDIM-1:0][DIM_BITS:0]   len,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [nrim_pkg::INDEX_W-1:0]            index,
  output logic                                    clip
);

  localparam int IW   = nrim_pkg::INDEX_W;
  localparam int LW   = DIM_BITS + 1;
  localparam int AW_A = 2 * DIM_BITS + 1;
  localparam int PW_B = AW_A + LW;
  localparam int PW_C = IW + LW;
  localparam int QW   = 2 * LW;

  logic                va;
  logic                vb;
  logic                vc;
  logic                rdy_a;
  logic                rdy_b;
  logic                rdy_c;
  logic [AW_A-1:0]     acc_a;
  logic [AW_A-1:0]     acc_a_next;
  logic [DIM_BITS-1:0] s2_a;
  logic [DIM_BITS-1:0] s3_a;
  logic                clip_a;
  logic [IW-1:0]       acc_b;
  logic [IW-1:0]       acc_b_next;
  logic [DIM_BITS-1:0] s3_b;
  logic                clip_b;
  logic [IW-1:0]       acc_c_next;
  logic [PW_B-1:0]     prod_b;
  logic [PW_C-1:0]     prod_c;

  assign rdy_c     = !vc || out_ready;
  assign rdy_b     = !vb || rdy_c;
  assign rdy_a     = !va || rdy_b;
  assign in_ready  = rdy_a;
  assign out_valid = vc;

  // Stage A: outer two coordinates.
  assign acc_a_next = AW_A'(src[0]) * AW_A'(len[1]) + AW_A'(src[1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (rdy_a) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy_a) begin
      acc_a  <= acc_a_next;
      s2_a   <= src[2];
      s3_a   <= src[3];
      clip_a <= clip_in;
    end
  end

  // Stage B: fold in the third coordinate.
  assign prod_b     = PW_B'(acc_a) * PW_B'(len[2]);
  assign acc_b_next = IW'(prod_b) + IW'(s2_a);

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (rdy_b) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (va && rdy_b) begin
      acc_b  <= acc_b_next;
      s3_b   <= s3_a;
      clip_b <= clip_a;
    end
  end

  // Stage C: fold in the innermost coordinate; the index wraps at its width.
  assign prod_c     = PW_C'(acc_b) * PW_C'(len[3]);
  assign acc_c_next = IW'(prod_c) + IW'(s3_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (rdy_c) begin
      vc <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (vb && rdy_c) begin
      index <= acc_c_next;
      clip  <= clip_b;
    end
  end

  // The partial index of the outer two dimensions stays below their element count.
  `NRIM_ASSERT(a_part_range, va, QW'(acc_a) < QW'(len[0]) * QW'(len[1]), "partial index too large")

endmodule

FILE: design/nearest_resize_index_map_core.sv
`timescale 1ns / 1ps
// Nearest-neighbor resize index map, aligned corners: one output coordinate in, one
// source index out, every cycle, five register stages from accepted word to result
// (one multiply stage, one round-and-clamp stage, three flat-index multiply-add stages).
// A stall on the result side backs up through per-stage ready logic, so empty stages keep
// filling while a finished word waits. Write registers through the cfg port only while no
// word is in flight (not enforced); sizes and ratios act combinationally on the datapath.
// Depends on nrim_pkg, nrim_cfg, nrim_scale, nrim_flatten and the macro header.
`include "nearest_resize_index_map_core_defines.svh"
module nearest_resize_index_map_core #(
  parameter int RANK      = nrim_pkg::RANK_DEF,
  parameter int FRAC_BITS = nrim_pkg::FRAC_BITS_DEF,
  parameter int DIM_BITS  = nrim_pkg::DIM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [nrim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nrim_pkg::RATIO_W-1:0]   cfg_data,
  input  logic                           item_valid,
  output logic                           item_stall,
  input  logic [nrim_pkg::COORD_W-1:0]   out_coord_0,
  input  logic [nrim_pkg::COORD_W-1:0]   out_coord_1,
  input  logic [nrim_pkg::COORD_W-1:0]   out_coord_2,
  input  logic [nrim_pkg::COORD_W-1:0]   out_coord_3,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [nrim_pkg::INDEX_W-1:0]   source_index,
  output logic                           clamped
);

  logic [nrim_pkg::NDIM-1:0][nrim_pkg::RATIO_W-1:0] ratio;
  logic [nrim_pkg::NDIM-1:0][DIM_BITS:0]            len;
  logic [nrim_pkg::NDIM-1:0][DIM_BITS-1:0]          len_m1;
  logic [nrim_pkg::NDIM-1:0][nrim_pkg::COORD_W-1:0] coord;
  logic [nrim_pkg::NDIM-1:0][DIM_BITS-1:0]          src;
  logic                                             scale_valid;
  logic                                             scale_ready;
  logic                                             flat_ready;
  logic                                             src_clip;

  // Outermost dimension sits at index zero.
  assign coord[0] = out_coord_0;
  assign coord[1] = out_coord_1;
  assign coord[2] = out_coord_2;
  assign coord[3] = out_coord_3;

  // Registers and effective sizes.
  nrim_cfg #(
    .RANK      (RANK),
    .FRAC_BITS (FRAC_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ratio     (ratio),
    .len       (len),
    .len_m1    (len_m1)
  );

  // Scale, round and clamp.
  nrim_scale #(
    .RANK      (RANK),
    .FRAC_BITS (FRAC_BITS),
    .DIM_BITS  (DIM_BITS)
  ) u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item_valid),
    .in_ready  (scale_ready),
    .coord     (coord),
    .ratio     (ratio),
    .len_m1    (len_m1),
    .out_valid (scale_valid),
    .out_ready (flat_ready),
    .src       (src),
    .clip      (src_clip)
  );

  // Flat row-major index.
  nrim_flatten #(
    .DIM_BITS  (DIM_BITS)
  ) u_flatten (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scale_valid),
    .in_ready  (flat_ready),
    .src       (src),
    .clip_in   (src_clip),
    .len       (len),
    .out_valid (result_valid),
    .out_ready (!result_stall),
    .index     (source_index),
    .clip      (clamped)
  );

  assign item_stall = !scale_ready;

  // Input backpressure only ever comes from a stalled result side.
  `NRIM_ASSERT(a_stall_source, item_stall, result_stall, "input stalled without result stall")
  // With the result register empty the whole pipe can move.
  `NRIM_ASSERT(a_empty_takes, !result_valid, !item_stall, "input stalled with empty output")

endmodule

FILE: verif/tb_nearest_resize_index_map_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for nearest_resize_index_map_core: directed table, then random setups.
// Every accepted word is predicted in the testbench and compared with the result words.
// Depends on nrim_pkg and the design files only.
module tb_nearest_resize_index_map_core;

  localparam int NDIM           = nrim_pkg::NDIM;
  localparam int LEN_W          = nrim_pkg::LEN_W;
  localparam int RATIO_W        = nrim_pkg::RATIO_W;
  localparam int COORD_W        = nrim_pkg::COORD_W;
  localparam int INDEX_W        = nrim_pkg::INDEX_W;
  localparam int CFG_IDX_W      = nrim_pkg::CFG_IDX_W;
  localparam int RANK           = nrim_pkg::RANK_DEF;
  localparam int FRAC_BITS      = nrim_pkg::FRAC_BITS_DEF;
  localparam int DIM_BITS       = nrim_pkg::DIM_BITS_DEF;
  localparam logic [63:0] SIZE_CAP  = 64'd1 << DIM_BITS;
  localparam logic [63:0] ROUND_BIT = 64'd1 << (FRAC_BITS - 1);
  localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << FRAC_BITS;
  localparam logic [INDEX_W-1:0] INDEX_MAX = '1;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = 12;
  localparam int HOLD_CYCLES    = 64;
  localparam int PHASES         = 10;
  localparam int WORDS_PER_PHASE = 100;
  localparam int CYCLE_LIMIT    = 200000;

  typedef logic [NDIM-1:0][COORD_W-1:0] coords_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic               clamped;
  } source_t;

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_t;

  typedef struct {
    row_kind_t           kind;
    nrim_pkg::cfg_reg_t  sel;
    logic [RATIO_W-1:0]  value;
    coords_t             coords;
    logic                typed;
    source_t             want;
  } row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [RATIO_W-1:0] cfg_data;
  logic item_valid;
  logic item_stall;
  logic [COORD_W-1:0] out_coord_0;
  logic [COORD_W-1:0] out_coord_1;
  logic [COORD_W-1:0] out_coord_2;
  logic [COORD_W-1:0] out_coord_3;
  logic result_valid;
  logic result_stall;
  logic [INDEX_W-1:0] source_index;
  logic clamped;

  // Testbench copy of the size and ratio registers.
  logic [LEN_W-1:0]   len_reg [NDIM];
  logic [RATIO_W-1:0] ratio_reg [NDIM];

  // Expected source words, oldest first.
  source_t source_q [$];

  // Typed expectation that travels with the word on the input port.
  logic    word_typed = 1'b0;
  source_t typed_want = '0;

  int   error_count = 0;
  int   words_in = 0;
  int   cycle_count = 0;
  int   burst_left = 0;
  logic hold_req = 1'b0;
  row_t dir_tab [$];

  nearest_resize_index_map_core uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .out_coord_0  (out_coord_0),
    .out_coord_1  (out_coord_1),
    .out_coord_2  (out_coord_2),
    .out_coord_3  (out_coord_3),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .source_index (source_index),
    .clamped      (clamped)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scale, round half up and clamp each coordinate, then fold into a row-major index.
  function automatic source_t map_to_source(input coords_t c);
    source_t     r;
    logic [63:0] flat;
    logic [63:0] size;
    logic [63:0] prod;
    logic [63:0] rounded;
    logic [63:0] src;
    r.clamped = 1'b0;
    flat = '0;
    for (int d = 0; d < NDIM; d++) begin
      if (d < NDIM - RANK || len_reg[d] == '0) begin
        size = 64'd1;
      end else if (64'(len_reg[d]) > SIZE_CAP) begin
        size = SIZE_CAP;
      end else begin
        size = 64'(len_reg[d]);
      end
      src = '0;
      if (d >= NDIM - RANK) begin
        prod = 64'(c[d]) * 64'(ratio_reg[d]);
        rounded = (prod + ROUND_BIT) >> FRAC_BITS;
        if (rounded > size - 1) begin
          src = size - 1;
          r.clamped = 1'b1;
        end else begin
          src = rounded;
        end
      end
      flat = flat * size + src;
    end
    r.index = flat[INDEX_W-1:0];
    return r;
  endfunction

  function automatic row_t cfg_row(input nrim_pkg::cfg_reg_t sel,
                                   input logic [RATIO_W-1:0] value);
    row_t r;
    r = '{kind: ROW_CFG, sel: sel, value: value, coords: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t word_row(input logic [COORD_W-1:0] c0, input logic [COORD_W-1:0] c1,
                                    input logic [COORD_W-1:0] c2, input logic [COORD_W-1:0] c3,
                                    input logic typed, input logic [INDEX_W-1:0] index,
                                    input logic clip);
    row_t    r;
    coords_t c;
    c[0] = c0;
    c[1] = c1;
    c[2] = c2;
    c[3] = c3;
    r = '{kind: ROW_WORD, sel: nrim_pkg::REG_IN_LEN_0, value: '0, coords: c, typed: typed,
          want: '{index: index, clamped: clip}};
    return r;
  endfunction

  task automatic check_field(input string name, input logic [INDEX_W-1:0] want,
                             input logic [INDEX_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
    end
  endtask

  // Register writes, word acceptance and result comparison, all sampled at the rising edge.
  always @(posedge clk) begin : monitor
    coords_t c;
    source_t want;
    if (rst) begin
      for (int d = 0; d < NDIM; d++) begin
        len_reg[d] = LEN_W'(1);
        ratio_reg[d] = RATIO_ONE;
      end
      source_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (nrim_pkg::cfg_reg_t'(cfg_index))
          nrim_pkg::REG_IN_LEN_0: len_reg[0] = cfg_data[LEN_W-1:0];
          nrim_pkg::REG_IN_LEN_1: len_reg[1] = cfg_data[LEN_W-1:0];
          nrim_pkg::REG_IN_LEN_2: len_reg[2] = cfg_data[LEN_W-1:0];
          nrim_pkg::REG_IN_LEN_3: len_reg[3] = cfg_data[LEN_W-1:0];
          nrim_pkg::REG_RATIO_0:  ratio_reg[0] = cfg_data;
          nrim_pkg::REG_RATIO_1:  ratio_reg[1] = cfg_data;
          nrim_pkg::REG_RATIO_2:  ratio_reg[2] = cfg_data;
          nrim_pkg::REG_RATIO_3:  ratio_reg[3] = cfg_data;
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        words_in++;
        // Ask the receiver for a long hold-off in the middle of the random traffic.
        if (words_in == 250 || words_in == 650) begin
          hold_req = 1'b1;
        end
        c[0] = out_coord_0;
        c[1] = out_coord_1;
        c[2] = out_coord_2;
        c[3] = out_coord_3;
        want = word_typed ? typed_want : map_to_source(c);
        source_q.push_back(want);
      end
      if (result_valid && !result_stall) begin
        if (source_q.size() == 0) begin
          error_count++;
          $error("result word with nothing expected: source_index %0h, clamped %0b",
                 source_index, clamped);
        end else begin
          want = source_q.pop_front();
          check_field("source_index", want.index, source_index);
          check_field("clamped", INDEX_W'(want.clamped), INDEX_W'(clamped));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: stall pattern in segments of random mode, plus requested long hold-offs.
  initial begin : receiver
    int seg_left;
    int mode;
    int tick;
    seg_left = 0;
    mode = 0;
    tick = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(10, 80);
      end
      seg_left--;
      tick++;
      case (mode)
        0:       result_stall <= 1'b0;
        1:       result_stall <= ($urandom_range(0, 2) == 0);
        2:       result_stall <= (tick % 3 == 0);
        default: result_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // Offer one word in bursts with random gaps; returns at the falling edge after acceptance.
  task automatic send_word(input coords_t c, input logic typed, input source_t want);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(40, 150);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
      end
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    out_coord_0 <= c[0];
    out_coord_1 <= c[1];
    out_coord_2 <= c[2];
    out_coord_3 <= c[3];
    word_typed = typed;
    typed_want = want;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
  endtask

  // Stop offering words and let the pipeline empty before touching registers.
  task automatic settle_idle();
    item_valid <= 1'b0;
    while (source_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
  task automatic write_reg(input nrim_pkg::cfg_reg_t sel, input logic [RATIO_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic               cfg_busy;
    coords_t            c;
    int                 in_sz;
    int                 out_sz;
    int                 pick;
    int                 osz [NDIM];
    logic [RATIO_W-1:0] lv [NDIM];
    logic [RATIO_W-1:0] rv [NDIM];
    longint             ratio_calc;

    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = nrim_pkg::REG_IN_LEN_0;
    cfg_data = '0;
    item_valid = 1'b0;
    out_coord_0 = '0;
    out_coord_1 = '0;
    out_coord_2 = '0;
    out_coord_3 = '0;
    cfg_busy = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset sizes are all one, so every nonzero coordinate clamps to index zero.
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h0, 1'b1, '0, 1'b0));
    dir_tab.push_back(word_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, '0, 1'b1));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h1, 1'b1, '0, 1'b1));
    dir_tab.push_back(word_row(16'h1, 16'h0, 16'h0, 16'h0, 1'b1, '0, 1'b1));
    // Largest sizes at unit ratio: corners of the full 48-bit index space.
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_0, 28'd4096));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_1, 28'd4096));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_2, 28'd4096));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_3, 28'd4096));
    dir_tab.push_back(word_row(16'd4095, 16'd4095, 16'd4095, 16'd4095, 1'b1, INDEX_MAX, 1'b0));
    dir_tab.push_back(word_row(16'd4096, 16'h0, 16'h0, 16'h0, 1'b1, 48'hFFF0_0000_0000, 1'b1));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h1, 1'b1, 48'h1, 1'b0));
    dir_tab.push_back(word_row(16'h1, 16'h0, 16'h0, 16'h0, 1'b1, 48'h0010_0000_0000, 1'b0));
    dir_tab.push_back(word_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, INDEX_MAX, 1'b1));
    // Zero size, oversize, size written with high junk bits; half ratios, zero and max ratio.
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_0, 28'd0));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_1, 28'd8191));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_2, 28'hABC0007));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_3, 28'd3));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_RATIO_0, 28'h0008000));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_RATIO_1, 28'h0000000));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_RATIO_2, 28'hFFFFFFF));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_RATIO_3, 28'h0008000));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h1, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h3, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h4, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h5, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'h0, 16'hFFFF, 16'h0, 16'h0, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h1, 16'h0, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'h1, 16'h0, 16'h0, 16'h0, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'hFFFF, 16'h0, 16'hFFFF, 16'hFFFF, 1'b0, '0, 1'b0));
    // Ratio just under one half: a product just below the rounding point.
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_1, 28'd4097));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_IN_LEN_3, 28'd4096));
    dir_tab.push_back(cfg_row(nrim_pkg::REG_RATIO_3, 28'h0007FFF));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h1, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'h2, 1'b0, '0, 1'b0));
    dir_tab.push_back(word_row(16'h0, 16'h0, 16'h0, 16'hFFFF, 1'b0, '0, 1'b0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        if (!cfg_busy) begin
          settle_idle();
          cfg_busy = 1'b1;
        end
        write_reg(dir_tab[i].sel, dir_tab[i].value);
      end else begin
        if (cfg_busy) begin
          cfg_valid <= 1'b0;
          cfg_busy = 1'b0;
        end
        send_word(dir_tab[i].coords, dir_tab[i].typed, dir_tab[i].want);
      end
    end

    // Random resize setups: ratios as software would load them, plus raw register noise.
    for (int p = 0; p < PHASES; p++) begin
      settle_idle();
      for (int d = 0; d < NDIM; d++) begin
        case (p % 4)
          0: begin
            in_sz = $urandom_range(1, 16);
            out_sz = $urandom_range(1, 64);
          end
          1: begin
            in_sz = $urandom_range(1, 4096);
            out_sz = $urandom_range(1, 65536);
          end
          2: begin
            in_sz = ($urandom_range(0, 1) == 1) ? 4096 : 1;
            case ($urandom_range(0, 3))
              0:       out_sz = 1;
              1:       out_sz = 2;
              2:       out_sz = 4096;
              default: out_sz = 65536;
            endcase
          end
          default: begin
            in_sz = 1;
            out_sz = 65536;
          end
        endcase
        if (in_sz == out_sz) begin
          ratio_calc = longint'(RATIO_ONE);
        end else if (out_sz == 1) begin
          ratio_calc = 0;
        end else begin
          ratio_calc = (longint'(in_sz - 1) * 65536 + (out_sz - 1) / 2) / (out_sz - 1);
        end
        lv[d] = RATIO_W'(in_sz);
        rv[d] = RATIO_W'(ratio_calc);
        if (p % 4 == 3) begin
          lv[d] = RATIO_W'($urandom_range(0, 8191));
          rv[d] = RATIO_W'($urandom);
        end
        osz[d] = out_sz;
      end
      write_reg(nrim_pkg::REG_IN_LEN_0, lv[0]);
      write_reg(nrim_pkg::REG_IN_LEN_1, lv[1]);
      write_reg(nrim_pkg::REG_IN_LEN_2, lv[2]);
      write_reg(nrim_pkg::REG_IN_LEN_3, lv[3]);
      write_reg(nrim_pkg::REG_RATIO_0, rv[0]);
      write_reg(nrim_pkg::REG_RATIO_1, rv[1]);
      write_reg(nrim_pkg::REG_RATIO_2, rv[2]);
      write_reg(nrim_pkg::REG_RATIO_3, rv[3]);
      cfg_valid <= 1'b0;

      // Mostly in-range coordinates, with edges and full-width noise mixed in.
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        for (int d = 0; d < NDIM; d++) begin
          pick = $urandom_range(0, 9);
          if (pick < 7) begin
            c[d] = COORD_W'($urandom_range(0, osz[d] - 1));
          end else if (pick == 7) begin
            c[d] = ($urandom_range(0, 1) == 1) ? COORD_W'(osz[d] - 1) : '0;
          end else if (pick == 8) begin
            c[d] = (osz[d] > 65535) ? 16'hFFFF : COORD_W'(osz[d]);
          end else begin
            c[d] = COORD_W'($urandom);
          end
        end
        send_word(c, 1'b0, '0);
      end
    end

    // Drain the pipeline and watch for stray results.
    item_valid <= 1'b0;
    while (source_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
